// File: rtl/core/sps_pkg.sv
// ============================================================================
// sps_pkg: shared definitions for the streaming prime sieve
// Sizes, word types and the status group passed from the modulo unit.
// ============================================================================
package sps_pkg;

  localparam int unsigned MAX_PRIMES = 64;
  localparam int unsigned VALUE_BITS = 16;

  // Table index and fill count widths.
  localparam int unsigned IDX_BITS = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int unsigned CNT_BITS = $clog2(MAX_PRIMES + 1);

  // The modulo unit retires this many quotient bits per cycle.
  localparam int unsigned RADIX_BITS = 4;
  localparam int unsigned MOD_CYCLES = (VALUE_BITS + RADIX_BITS - 1) / RADIX_BITS;
  localparam int unsigned DVD_BITS   = MOD_CYCLES * RADIX_BITS;
  localparam int unsigned CYC_BITS   = $clog2(MOD_CYCLES + 1);

  typedef struct packed {
    logic                  start_req;
    logic [VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prime;
    logic                  stored;
  } out_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_status_t;

endpackage

// File: rtl/core/sps_ram.sv
// ============================================================================
// sps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ============================================================================
module sps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sps_mod.sv
// ============================================================================
// sps_mod: iterative modulo unit
// Restoring division, RADIX_BITS remainder steps per cycle; reports whether
// the remainder is zero once the last step is done.
// ============================================================================
module sps_mod import sps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output mod_status_t           status_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CYC_BITS-1:0]   cyc_q, cyc_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [DVD_BITS-1:0]   dvd_q, dvd_d;
  logic [VALUE_BITS-1:0] div_q, div_d;

  always_comb begin
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS-1:0] rem;
    logic [DVD_BITS-1:0]   dvd;
    rem    = rem_q;
    dvd    = dvd_q;
    busy_d = busy_q;
    cyc_d  = cyc_q;
    div_d  = div_q;
    done_d = 1'b0;
    // The remainder always stays below the divisor, so one extra bit holds
    // the shifted value.
    for (int unsigned s = 0; s < RADIX_BITS; s++) begin
      trial = {rem, dvd[DVD_BITS-1]};
      dvd   = {dvd[DVD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem = trial[VALUE_BITS-1:0];
    end
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cyc_d  = CYC_BITS'(MOD_CYCLES);
      rem_d  = '0;
      dvd_d  = DVD_BITS'(dividend_i);
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem;
      dvd_d = dvd;
      cyc_d = cyc_q - CYC_BITS'(1);
      if (cyc_q == CYC_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cyc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cyc_q  <= cyc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

// File: rtl/core/streaming_prime_sieve.sv
// ============================================================================
// streaming_prime_sieve: bounded-table prime sieve by trial division
// Tests each candidate word against the stored primes and emits primes.
// ============================================================================
// Usage. Candidate words arrive on the input channel (in_valid_i, in_stall_o,
// in_data_i) in ascending order from two. A word with start_req set empties
// the prime table before its value is tested. Values below two are dropped.
// A candidate that no stored prime divides leaves on the output channel
// (out_valid_o, out_stall_i, out_data_o) with stored set when it was
// appended to the table, or clear when the table was already full.
// Flow. The table sits in a RAM with a registered read, and one modulo
// unit serves all the divisions. Each stored prime is tested in these steps:
// a RAM read, a start of the unit, the division and a step to act on the
// remainder flag. A word that no stored prime divides is then emitted. A
// word is accepted only while the block is idle.
// Reset clears the fill count and the control state; the table RAM is not
// cleared, since entries at or above the fill count are never read.
// Stalling. The result sits in an output register. The block goes on
// accepting and testing the next word while that result waits; it holds a
// second result until the register is free.
// ============================================================================
module streaming_prime_sieve import sps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [VALUE_BITS-1:0] cand_q, cand_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  in_accept;
  logic                  out_free;
  logic [CNT_BITS-1:0]   count_eff;
  logic [CNT_BITS-1:0]   idx_next;
  logic                  table_full;
  logic                  ram_we;
  logic                  ram_re;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  mod_start;
  mod_status_t           mod_st;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign count_eff  = in_data_i.start_req ? '0 : count_q;
  assign idx_next   = CNT_BITS'(idx_q) + CNT_BITS'(1);
  assign table_full = (count_q >= CNT_BITS'(MAX_PRIMES));

  assign ram_re    = (state_q == S_READ);
  assign mod_start = (state_q == S_START);
  assign ram_we    = (state_q == S_EMIT) && out_free && !table_full;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          count_d = count_eff;
          cand_d  = in_data_i.value;
          idx_d   = '0;
          if (in_data_i.value < VALUE_BITS'(2)) begin
            state_d = S_IDLE;
          end else if (count_eff == '0) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_START;
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mod_st.done) begin
          if (mod_st.rem_zero) begin
            // A stored prime divides the candidate: drop it.
            state_d = S_IDLE;
          end else if (idx_next == count_q) begin
            state_d = S_EMIT;
          end else begin
            idx_d   = idx_q + IDX_BITS'(1);
            state_d = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.prime  = cand_q;
          out_d.stored = !table_full;
          if (!table_full) begin
            count_d = count_q + CNT_BITS'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    out_q  <= out_d;
  end

  sps_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_PRIMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_BITS-1:0]),
    .wdata_i (cand_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  sps_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cand_q),
    .divisor_i  (ram_rdata),
    .status_o   (mod_st)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(MAX_PRIMES))
    else $error("prime count exceeds table size");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_st.done |-> state_q == S_WAIT)
    else $error("modulo result outside the wait state");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> CNT_BITS'(idx_q) < count_q)
    else $error("table read beyond fill count");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + CNT_BITS'(1))
    else $error("table write without count increment");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> out_valid_q && out_q.prime == $past(cand_q))
    else $error("emitted result not loaded");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the streaming prime sieve
// Feeds candidate words on the input channel and compares every prime that
// leaves the block with a predictor that keeps its own prime table.
// ============================================================================
module testbench;
  import sps_pkg::*;

  // Word budget for the whole run; the random part tops it up after the
  // directed table and the forced runs.
  localparam int unsigned RANDOM_WORDS    = 1000;
  // Worst case for one word: a full table, and for each stored prime a RAM
  // read, a start, the division and a step to act on the result, plus a
  // margin.
  localparam int unsigned SETTLE_CYCLES   = 1 + (MOD_CYCLES + 3) * MAX_PRIMES + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  // About 1000 words at the worst case each, sender gaps and the long hold-off
  // stay well below this limit.
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  typedef enum logic [1:0] {
    RUN_FROM_TWO, RUN_FROM_BASE, RUN_NOISE
  } run_kind_e;

  typedef struct packed {
    in_t  word;
    logic typed;
    logic emits;
    out_t res;
  } directed_row_t;

  // Rows marked typed carry a result that can be read off directly; the rest
  // are checked against the predictor.
  localparam int unsigned N_DIRECTED = 22;
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{1'b0, 16'd0},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd1},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd2},     1'b1, 1'b1, '{16'd2, 1'b1}},
    '{'{1'b0, 16'd3},     1'b1, 1'b1, '{16'd3, 1'b1}},
    '{'{1'b0, 16'd4},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd5},     1'b1, 1'b1, '{16'd5, 1'b1}},
    '{'{1'b0, 16'd2},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd7},     1'b1, 1'b1, '{16'd7, 1'b1}},
    '{'{1'b1, 16'd1},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd4},     1'b1, 1'b1, '{16'd4, 1'b1}},
    '{'{1'b0, 16'd8},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd6},     1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd65535}, 1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b1, 16'd65535}, 1'b1, 1'b1, '{16'd65535, 1'b1}},
    '{'{1'b0, 16'd65534}, 1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd32768}, 1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b1, 16'd0},     1'b1, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'd2},     1'b1, 1'b1, '{16'd2, 1'b1}},
    '{'{1'b0, 16'h5555},  1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b0, 16'hAAAA},  1'b0, 1'b0, '{16'd0, 1'b0}},
    '{'{1'b1, 16'hAAAA},  1'b1, 1'b1, '{16'hAAAA, 1'b1}},
    '{'{1'b0, 16'h5555},  1'b0, 1'b0, '{16'd0, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  streaming_prime_sieve dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Predictor state: the primes stored so far and how many there are.
  logic [VALUE_BITS-1:0] sieve_table [MAX_PRIMES];
  int unsigned           sieve_count;

  out_t        pending_primes [$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned clears_sent;
  int unsigned primes_checked;
  int unsigned unstored_checked;
  int unsigned drains_done;
  int unsigned burst_left;
  bit          gap_enable;
  bit          hold_off_req;
  longint unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out whether a word yields a prime and updates the prime table.
  function automatic bit predict_prime(input in_t word, output out_t res);
    logic [VALUE_BITS-1:0] cand;
    cand = word.value;
    res  = '0;
    if (word.start_req) begin
      sieve_count = 0;
    end
    if (cand < 2) begin
      return 1'b0;
    end
    for (int unsigned i = 0; i < sieve_count; i++) begin
      if (cand % sieve_table[i] == 0) begin
        return 1'b0;
      end
    end
    res.prime = cand;
    if (sieve_count < MAX_PRIMES) begin
      sieve_table[sieve_count] = cand;
      sieve_count++;
      res.stored = 1'b1;
    end
    return 1'b1;
  endfunction

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input in_t word, input bit typed, input bit typed_emits,
                           input out_t typed_res);
    out_t res;
    bit   emits;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    emits = predict_prime(word, res);
    if (typed) begin
      emits = typed_emits;
      res   = typed_res;
    end
    if (emits) begin
      pending_primes.push_back(res);
    end
    words_sent++;
    if (word.start_req) begin
      clears_sent++;
    end
  endtask

  task automatic idle_for(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Bursts of random length, with a random gap before each when gaps are on.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_enable) begin
        idle_for($urandom_range(1, 12));
      end
    end
    burst_left--;
  endtask

  // Ascending run that starts with a table clear.
  task automatic send_run(input logic [VALUE_BITS-1:0] first, input int unsigned count);
    in_t w;
    for (int unsigned n = 0; n < count; n++) begin
      pace_sender();
      w.start_req = (n == 0);
      w.value     = first + VALUE_BITS'(n);
      send_word(w, 1'b0, 1'b0, '0);
    end
  endtask

  task automatic drain_block();
    idle_for(1);
    while (pending_primes.size() != 0) @(posedge clk_i);
    drains_done++;
  endtask

  // Receiver: stall patterns of its own, plus one long hold-off on request.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 300);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (hold_off_req) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
          hold_off_req = 1'b0;
        end
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 80);
          STALL_PERIODIC: out_stall_i <= ((k % 7) < 3);
          default:        out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Result checker: each accepted word is compared with the oldest prime due.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result: prime=%0d stored=%0b", out_data_o.prime,
               out_data_o.stored);
        error_count++;
      end else begin
        want = pending_primes.pop_front();
        if (out_data_o.prime !== want.prime) begin
          $error("field prime: expected %0d, actual %0d", want.prime, out_data_o.prime);
          error_count++;
        end
        if (out_data_o.stored !== want.stored) begin
          $error("field stored: expected %0b, actual %0b", want.stored, out_data_o.stored);
          error_count++;
        end
        primes_checked++;
        if (!want.stored) begin
          unstored_checked++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    in_t         w;
    run_kind_e   kind;
    int unsigned target;
    int unsigned run_len;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    hold_off_req     = 1'b0;
    gap_enable       = 1'b1;
    burst_left       = 0;
    sieve_count      = 0;
    error_count      = 0;
    words_sent       = 0;
    clears_sent      = 0;
    primes_checked   = 0;
    unstored_checked = 0;
    drains_done      = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: drops below two, repeats, clears and the field extremes.
    foreach (DIRECTED_ROWS[r]) begin
      send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].emits,
                DIRECTED_ROWS[r].res);
    end
    drain_block();

    // The receiver holds off for a long stretch while words keep coming, so
    // the output side fills and the block stalls its input.
    hold_off_req = 1'b1;
    gap_enable   = 1'b0;
    send_run(16'd2, 80);
    drain_block();

    // One run from two fills the table with the first primes; one from a high
    // base lets composites through, since its table holds no small primes.
    gap_enable = 1'b1;
    send_run(16'd2, 360);
    send_run(VALUE_BITS'($urandom_range(20000, 65000)), 120);

    target = words_sent + RANDOM_WORDS - 580;
    while (words_sent < target) begin
      gap_enable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = RUN_FROM_TWO;
        6, 7:             kind = RUN_FROM_BASE;
        default:          kind = RUN_NOISE;
      endcase
      case (kind)
        RUN_FROM_TWO: begin
          run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(320, 450)
                                                : $urandom_range(10, 120);
          if (run_len > target - words_sent) begin
            run_len = target - words_sent;
          end
          send_run(16'd2, run_len);
        end
        RUN_FROM_BASE: begin
          run_len = $urandom_range(20, 150);
          if (run_len > target - words_sent) begin
            run_len = target - words_sent;
          end
          send_run(VALUE_BITS'($urandom_range(2, 65535 - run_len)), run_len);
        end
        default: begin
          // Noise: stray clears, arbitrary values, drops, repeats of stored
          // primes and small values out of order.
          repeat ($urandom_range(1, 20)) begin
            pace_sender();
            w.start_req = ($urandom_range(0, 15) == 0);
            case ($urandom_range(0, 3))
              0: w.value = VALUE_BITS'($urandom);
              1: w.value = VALUE_BITS'($urandom_range(0, 1));
              2: w.value = (sieve_count != 0) ? sieve_table[$urandom_range(0, sieve_count - 1)]
                                              : 16'd2;
              default: w.value = VALUE_BITS'($urandom_range(2, 400));
            endcase
            send_word(w, 1'b0, 1'b0, '0);
          end
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        drain_block();
      end
    end

    drain_block();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d words with %0d table clears; checked %0d primes, %0d of them unstored.",
             words_sent, clears_sent, primes_checked, unstored_checked);
    $display("Output held off once for %0d cycles; the block was drained %0d times.",
             HOLD_OFF_CYCLES, drains_done);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
